[rtl/linear_probe_hash_table_core_assert.svh]
// Assertion macros for the linear probe hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true at a clock edge.
`define LPHT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/lpht_pkg.sv]
// Shared types and constants of the linear probe hash table
package lpht_pkg;

  localparam int unsigned SLOTS_DEF     = 1024;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam int unsigned RES_W = 2;
  localparam logic [RES_W-1:0] RES_OK        = 2'd0;
  localparam logic [RES_W-1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [RES_W-1:0] RES_FULL      = 2'd2;
  localparam logic [RES_W-1:0] RES_RANGE     = 2'd3;

  localparam int unsigned MARK_W = 2;
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_CHECK = 4'b1000
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic check;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic stop;
  } dp_sts_t;

endpackage

[rtl/linear_probe_hash_table_core.sv]
// Top level of the linear probe hash table core
// Open-addressing key table with linear probing. After reset the core clears
// every slot to empty with busy high; configuration writes are taken during
// that time. A transaction is taken when start is high and busy is low. Its
// result appears on the result ports for exactly one cycle with done_o high
// and cannot be held off. A home slot or slot index out of range (or an
// unknown kind) answers in the cycle after the start; otherwise the core goes
// through its probe state, then its check state, which probes one slot for a
// delete and one to the effective table size for insert and find. One slot
// is probed per cycle through the registered read port of the slot RAM.
// table_size may only be written while busy is low and no result is pending.
module linear_probe_hash_table_core #(
  parameter int unsigned SLOTS     = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_WIDTH = lpht_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        table_size_we_i,
  input  logic [$clog2(SLOTS+1)-1:0]  table_size_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [lpht_pkg::KIND_W-1:0] kind_i,
  input  logic [KEY_WIDTH-1:0]        key_i,
  input  logic [$clog2(SLOTS)-1:0]    home_slot_i,
  input  logic [$clog2(SLOTS)-1:0]    slot_index_i,
  output logic                        done_o,
  output logic [lpht_pkg::RES_W-1:0]  status_o,
  output logic [$clog2(SLOTS)-1:0]    slot_o,
  output logic [$clog2(SLOTS+1)-1:0]  free_slots_o
);

  lpht_pkg::dp_cmd_t cmd;
  lpht_pkg::dp_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lpht_datapath #(
    .SLOTS    (SLOTS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .table_size_we_i(table_size_we_i),
    .table_size_i   (table_size_i),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .home_slot_i    (home_slot_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .free_slots_o   (free_slots_o)
  );

endmodule

[rtl/lpht_ram.sv]
// Generic simple dual-port RAM with registered read
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lpht_ctrl.sv]
// Operation sequencer of the linear probe hash table
module lpht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lpht_pkg::dp_sts_t sts_i,
  output lpht_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);

  lpht_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpht_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_IDLE: begin
        if (start_i && sts_i.in_range) state_d = lpht_pkg::S_PROBE;
      end
      lpht_pkg::S_PROBE: begin
        state_d = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (sts_i.stop) state_d = lpht_pkg::S_IDLE;
      end
      default: begin
        state_d = lpht_pkg::S_CLEAR;
      end
    endcase
  end

  assign cmd_o.clr_en = (state_q == lpht_pkg::S_CLEAR);
  assign cmd_o.accept = (state_q == lpht_pkg::S_IDLE) && start_i;
  assign cmd_o.check  = (state_q == lpht_pkg::S_CHECK);
  assign busy_o       = (state_q != lpht_pkg::S_IDLE);

endmodule

[rtl/lpht_datapath.sv]
// Slot store, probe position, counters and result registers
module lpht_datapath #(
  parameter int unsigned SLOTS     = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_WIDTH = lpht_pkg::KEY_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lpht_pkg::dp_cmd_t                 cmd_i,
  output lpht_pkg::dp_sts_t                 sts_o,
  input  logic                              table_size_we_i,
  input  logic [$clog2(SLOTS+1)-1:0]        table_size_i,
  input  logic [lpht_pkg::KIND_W-1:0]       kind_i,
  input  logic [KEY_WIDTH-1:0]              key_i,
  input  logic [$clog2(SLOTS)-1:0]          home_slot_i,
  input  logic [$clog2(SLOTS)-1:0]          slot_index_i,
  output logic                              done_o,
  output logic [lpht_pkg::RES_W-1:0]        status_o,
  output logic [$clog2(SLOTS)-1:0]          slot_o,
  output logic [$clog2(SLOTS+1)-1:0]        free_slots_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned MEM_W  = KEY_WIDTH + lpht_pkg::MARK_W;
  localparam logic [CNT_W-1:0]  SLOTS_C  = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);

  logic [CNT_W-1:0]            table_size_q;
  logic [lpht_pkg::KIND_W-1:0] kind_q;
  logic [KEY_WIDTH-1:0]        key_q;
  logic [SLOT_W-1:0]           pos_q;
  logic [CNT_W-1:0]            n_q;
  logic [CNT_W-1:0]            size_q;
  logic [CNT_W-1:0]            used_q, used_d;
  logic [SLOT_W-1:0]           clr_q;
  logic                        done_q;
  logic [lpht_pkg::RES_W-1:0]  status_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [CNT_W-1:0]            free_q, free_d;

  logic [CNT_W-1:0]            eff_size, size_sel, pos_inc, n_inc;
  logic [SLOT_W-1:0]           pos_next;
  logic                        last, in_range, hit, stop, we_op;
  logic [lpht_pkg::MARK_W-1:0] rd_mark, wmark;
  logic [KEY_WIDTH-1:0]        rd_key;
  logic [lpht_pkg::RES_W-1:0]  res_status;

  logic                        ram_we;
  logic [SLOT_W-1:0]           ram_waddr, ram_raddr;
  logic [MEM_W-1:0]            ram_wdata, ram_rdata;

  always_comb begin
    if (table_size_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (table_size_q > SLOTS_C) begin
      eff_size = SLOTS_C;
    end else begin
      eff_size = table_size_q;
    end
  end

  always_comb begin
    case (kind_i)
      lpht_pkg::KIND_INSERT, lpht_pkg::KIND_FIND: in_range = CNT_W'(home_slot_i) < eff_size;
      lpht_pkg::KIND_DELETE: in_range = CNT_W'(slot_index_i) < eff_size;
      default:               in_range = 1'b0;
    endcase
  end

  assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_next = (pos_inc == size_q) ? '0 : SLOT_W'(pos_inc);
  assign n_inc    = n_q + CNT_W'(1);
  assign last     = (n_inc == size_q);

  assign rd_mark = ram_rdata[MEM_W-1 -: lpht_pkg::MARK_W];
  assign rd_key  = ram_rdata[KEY_WIDTH-1:0];

  always_comb begin
    hit        = 1'b0;
    stop       = 1'b1;
    wmark      = lpht_pkg::MARK_LIVE;
    res_status = lpht_pkg::RES_RANGE;
    case (kind_q)
      lpht_pkg::KIND_INSERT: begin
        hit        = (rd_mark != lpht_pkg::MARK_LIVE);
        stop       = hit || last;
        res_status = hit ? lpht_pkg::RES_OK : lpht_pkg::RES_FULL;
      end
      lpht_pkg::KIND_FIND: begin
        hit        = (rd_mark == lpht_pkg::MARK_LIVE) && (rd_key == key_q);
        stop       = hit || (rd_mark == lpht_pkg::MARK_EMPTY) || last;
        res_status = hit ? lpht_pkg::RES_OK : lpht_pkg::RES_NOT_FOUND;
      end
      lpht_pkg::KIND_DELETE: begin
        hit        = (rd_mark == lpht_pkg::MARK_LIVE);
        wmark      = lpht_pkg::MARK_DELETED;
        res_status = hit ? lpht_pkg::RES_OK : lpht_pkg::RES_NOT_FOUND;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign we_op = cmd_i.check && hit && (kind_q != lpht_pkg::KIND_FIND);

  always_comb begin
    used_d = used_q;
    if (cmd_i.check && hit) begin
      if (kind_q == lpht_pkg::KIND_INSERT) begin
        used_d = used_q + CNT_W'(1);
      end else if (kind_q == lpht_pkg::KIND_DELETE && used_q != '0) begin
        used_d = used_q - CNT_W'(1);
      end
    end
  end

  assign size_sel = cmd_i.accept ? eff_size : size_q;
  assign free_d   = (used_d >= size_sel) ? '0 : size_sel - used_d;

  assign ram_we    = cmd_i.clr_en || we_op;
  assign ram_waddr = cmd_i.clr_en ? clr_q : pos_q;
  assign ram_wdata = cmd_i.clr_en ? {lpht_pkg::MARK_EMPTY, KEY_WIDTH'(0)} : {wmark, key_q};
  assign ram_raddr = cmd_i.check ? pos_next : pos_q;

  lpht_ram #(
    .WIDTH(MEM_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SLOTS_C;
      used_q       <= '0;
      clr_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      if (table_size_we_i) table_size_q <= table_size_i;
      used_q <= used_d;
      if (cmd_i.clr_en) clr_q <= clr_q + SLOT_W'(1);
      done_q <= (cmd_i.accept && !in_range) || (cmd_i.check && stop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      size_q <= eff_size;
      pos_q  <= (kind_i == lpht_pkg::KIND_DELETE) ? slot_index_i : home_slot_i;
      n_q    <= '0;
      if (!in_range) begin
        status_q <= lpht_pkg::RES_RANGE;
        slot_q   <= '0;
        free_q   <= free_d;
      end
    end else if (cmd_i.check) begin
      if (stop) begin
        status_q <= res_status;
        slot_q   <= hit ? pos_q : '0;
        free_q   <= free_d;
      end else begin
        pos_q <= pos_next;
        n_q   <= n_inc;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == SLOT_MAX);
  assign sts_o.in_range = in_range;
  assign sts_o.stop     = stop;

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign free_slots_o = free_q;

endmodule

[rtl/lpht_checker.sv]
// Port-level checks of the linear probe hash table core and their binding
`include "linear_probe_hash_table_core_assert.svh"

module lpht_checker #(
  parameter int unsigned SLOTS = lpht_pkg::SLOTS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [lpht_pkg::RES_W-1:0] status_o,
  input logic [$clog2(SLOTS)-1:0]   slot_o,
  input logic [$clog2(SLOTS+1)-1:0] free_slots_o
);

  `LPHT_ASSERT(a_busy_rise, $rose(busy) |-> $past(start), "busy rose without a start")
  `LPHT_ASSERT(a_done_cause, done_o |-> $past(start) || $past(busy), "result without a transaction")
  `LPHT_ASSERT(a_slot_zero, done_o && status_o != lpht_pkg::RES_OK |-> slot_o == '0, "slot not zero on failure")
  `LPHT_NEVER(a_free_bound, done_o && free_slots_o > SLOTS, "free count above slot count")

endmodule

bind linear_probe_hash_table_core lpht_checker #(.SLOTS(SLOTS)) u_lpht_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the linear probe hash table core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = lpht_pkg::SLOTS_DEF;
  localparam int unsigned KW          = lpht_pkg::KEY_WIDTH_DEF;
  localparam int unsigned SW          = $clog2(SLOTS);
  localparam int unsigned CW          = $clog2(SLOTS + 1);
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [lpht_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [lpht_pkg::RES_W-1:0] status;
    logic [SW-1:0]              slot;
    logic [CW-1:0]              free;
  } table_answer_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          table_size_we_i = 1'b0;
  logic [CW-1:0]                 table_size_i    = '0;
  logic                          start           = 1'b0;
  logic                          busy;
  logic [lpht_pkg::KIND_W-1:0]   kind_i          = '0;
  logic [KW-1:0]                 key_i           = '0;
  logic [SW-1:0]                 home_slot_i     = '0;
  logic [SW-1:0]                 slot_index_i    = '0;
  logic                          done_o;
  logic [lpht_pkg::RES_W-1:0]    status_o;
  logic [SW-1:0]                 slot_o;
  logic [CW-1:0]                 free_slots_o;

  // shadow copy of the table
  logic [lpht_pkg::MARK_W-1:0] shadow_mark [SLOTS];
  logic [KW-1:0]               shadow_key  [SLOTS];
  logic [SW-1:0]               shadow_home [SLOTS];
  int unsigned                 shadow_used;
  logic [CW-1:0]               shadow_size;

  table_answer_t pending_answers [$];
  table_answer_t want_ans;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   idle_pct       = 0;

  always #5 clk_i = ~clk_i;

  linear_probe_hash_table_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_size_we_i(table_size_we_i),
    .table_size_i   (table_size_i),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .home_slot_i    (home_slot_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .free_slots_o   (free_slots_o)
  );

  function automatic int unsigned active_size();
    if (shadow_size == '0) return 1;
    if (shadow_size > CW'(SLOTS)) return SLOTS;
    return 32'(shadow_size);
  endfunction

  function automatic table_answer_t table_apply(input logic [lpht_pkg::KIND_W-1:0] op_kind,
                                                input logic [KW-1:0] op_key,
                                                input logic [SW-1:0] home,
                                                input logic [SW-1:0] victim);
    table_answer_t ans;
    int unsigned   s;
    int unsigned   pos;
    s = active_size();
    ans.status = lpht_pkg::RES_RANGE;
    ans.slot   = '0;
    if (op_kind == lpht_pkg::KIND_INSERT && 32'(home) < s) begin
      ans.status = lpht_pkg::RES_FULL;
      pos = 32'(home);
      for (int unsigned n = 0; n < s; n++) begin
        if (shadow_mark[pos] != lpht_pkg::MARK_LIVE) begin
          shadow_mark[pos] = lpht_pkg::MARK_LIVE;
          shadow_key[pos]  = op_key;
          shadow_home[pos] = home;
          shadow_used++;
          ans.status = lpht_pkg::RES_OK;
          ans.slot   = SW'(pos);
          break;
        end
        pos = (pos + 1 == s) ? 0 : pos + 1;
      end
    end else if (op_kind == lpht_pkg::KIND_FIND && 32'(home) < s) begin
      ans.status = lpht_pkg::RES_NOT_FOUND;
      pos = 32'(home);
      for (int unsigned n = 0; n < s; n++) begin
        if (shadow_mark[pos] == lpht_pkg::MARK_EMPTY) break;
        if (shadow_mark[pos] == lpht_pkg::MARK_LIVE && shadow_key[pos] == op_key) begin
          ans.status = lpht_pkg::RES_OK;
          ans.slot   = SW'(pos);
          break;
        end
        pos = (pos + 1 == s) ? 0 : pos + 1;
      end
    end else if (op_kind == lpht_pkg::KIND_DELETE && 32'(victim) < s) begin
      if (shadow_mark[victim] == lpht_pkg::MARK_LIVE) begin
        shadow_mark[victim] = lpht_pkg::MARK_DELETED;
        if (shadow_used > 0) shadow_used--;
        ans.status = lpht_pkg::RES_OK;
        ans.slot   = victim;
      end else begin
        ans.status = lpht_pkg::RES_NOT_FOUND;
      end
    end
    ans.free = (shadow_used >= s) ? '0 : CW'(s - shadow_used);
    return ans;
  endfunction

  function automatic int unsigned pick_live_slot();
    int unsigned s;
    int unsigned p;
    s = active_size();
    p = $urandom_range(s - 1);
    for (int unsigned n = 0; n < s; n++) begin
      if (shadow_mark[p] == lpht_pkg::MARK_LIVE) return p;
      p = (p + 1 == s) ? 0 : p + 1;
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction, status", 0, 32'(status_o));
      end else begin
        want_ans = pending_answers.pop_front();
        if (status_o !== want_ans.status)
          report_mismatch("status", 32'(want_ans.status), 32'(status_o));
        if (slot_o !== want_ans.slot)
          report_mismatch("slot", 32'(want_ans.slot), 32'(slot_o));
        if (free_slots_o !== want_ans.free)
          report_mismatch("free_slots", 32'(want_ans.free), 32'(free_slots_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // start stays high after a transaction unless a gap follows
  task automatic send_op(input logic [lpht_pkg::KIND_W-1:0] op_kind, input logic [KW-1:0] op_key,
                         input logic [SW-1:0] home, input logic [SW-1:0] victim);
    start        <= 1'b1;
    kind_i       <= op_kind;
    key_i        <= op_key;
    home_slot_i  <= home;
    slot_index_i <= victim;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_answers.push_back(table_apply(op_kind, op_key, home, victim));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_table_size(input logic [CW-1:0] value);
    wait_idle();
    table_size_we_i <= 1'b1;
    table_size_i    <= value;
    @(posedge clk_i);
    shadow_size     = value;
    table_size_we_i <= 1'b0;
  endtask

  task automatic random_op();
    int unsigned   s;
    int unsigned   pick;
    int unsigned   p;
    logic [KW-1:0] k;
    s    = active_size();
    pick = $urandom_range(99);
    k    = ($urandom_range(3) == 0) ? KW'($urandom_range(15)) : KW'($urandom);
    if (pick < 35) begin
      send_op(lpht_pkg::KIND_INSERT, k, SW'($urandom_range(s - 1)), SW'($urandom));
    end else if (pick < 60) begin
      p = pick_live_slot();
      if (p < s) send_op(lpht_pkg::KIND_FIND, shadow_key[p], shadow_home[p], SW'($urandom));
      else send_op(lpht_pkg::KIND_FIND, k, SW'($urandom_range(s - 1)), SW'($urandom));
    end else if (pick < 70) begin
      send_op(lpht_pkg::KIND_FIND, k, SW'($urandom_range(s - 1)), SW'($urandom));
    end else if (pick < 88) begin
      p = pick_live_slot();
      if (p < s) send_op(lpht_pkg::KIND_DELETE, KW'($urandom), SW'($urandom), SW'(p));
      else send_op(lpht_pkg::KIND_DELETE, KW'($urandom), SW'($urandom),
                   SW'($urandom_range(s - 1)));
    end else if (pick < 94) begin
      send_op(lpht_pkg::KIND_DELETE, KW'($urandom), SW'($urandom), SW'($urandom_range(s - 1)));
    end else if (s < SLOTS && $urandom_range(1) == 1) begin
      send_op($urandom_range(1) ? lpht_pkg::KIND_FIND : lpht_pkg::KIND_DELETE, k,
              SW'($urandom_range(SLOTS - 1, s)), SW'($urandom_range(SLOTS - 1, s)));
    end else begin
      send_op(KIND_UNUSED, k, SW'($urandom), SW'($urandom));
    end
  endtask

  task automatic test_reset_table();
    send_op(lpht_pkg::KIND_FIND, '0, '0, '0);
    send_op(lpht_pkg::KIND_INSERT, '1, SW'(SLOTS - 1), '0);
    send_op(lpht_pkg::KIND_INSERT, '0, SW'(SLOTS - 1), '0);
    send_op(lpht_pkg::KIND_FIND, '0, SW'(SLOTS - 1), '0);
    send_op(lpht_pkg::KIND_DELETE, '0, '0, SW'(SLOTS - 1));
    send_op(lpht_pkg::KIND_DELETE, '1, '1, SW'(SLOTS - 1));
    send_op(KIND_UNUSED, '1, '1, '1);
  endtask

  task automatic test_duplicate_keys();
    send_op(lpht_pkg::KIND_INSERT, 32'd5, 10'd10, '0);
    send_op(lpht_pkg::KIND_INSERT, 32'd5, 10'd10, '0);
    send_op(lpht_pkg::KIND_FIND, 32'd5, 10'd10, '0);
    send_op(lpht_pkg::KIND_DELETE, '0, '0, 10'd10);
    send_op(lpht_pkg::KIND_FIND, 32'd5, 10'd10, '0);
  endtask

  task automatic test_single_slot();
    write_table_size('0);
    send_op(lpht_pkg::KIND_INSERT, 32'h1234_5678, '0, '0);
    send_op(lpht_pkg::KIND_FIND, '0, '0, '0);
    send_op(lpht_pkg::KIND_INSERT, 32'h9, 10'd1, '0);
    send_op(lpht_pkg::KIND_DELETE, '0, '0, 10'd1);
    send_op(lpht_pkg::KIND_DELETE, '0, '0, '0);
    send_op(lpht_pkg::KIND_INSERT, 32'hA5A5_5A5A, '0, '0);
    write_table_size(11'd1);
    send_op(lpht_pkg::KIND_INSERT, 32'h77, '0, '0);
    send_op(lpht_pkg::KIND_FIND, 32'h77, '0, '0);
  endtask

  task automatic test_shrunk_table();
    write_table_size(11'd3);
    send_op(lpht_pkg::KIND_INSERT, 32'h100, 10'd2, '0);
    send_op(lpht_pkg::KIND_INSERT, 32'h101, 10'd2, '0);
    send_op(lpht_pkg::KIND_INSERT, 32'h102, 10'd1, '0);
    send_op(lpht_pkg::KIND_FIND, 32'h103, 10'd1, '0);
    write_table_size(11'h7FF);
    send_op(lpht_pkg::KIND_INSERT, '1, SW'(SLOTS - 1), '0);
  endtask

  task automatic test_random_traffic(input logic [CW-1:0] size, input int unsigned pct,
                                     input int unsigned count);
    write_table_size(size);
    idle_pct = pct;
    repeat (count) random_op();
    idle_pct = 0;
  endtask

  initial begin
    shadow_size = CW'(SLOTS);
    shadow_used = 0;
    for (int unsigned i = 0; i < SLOTS; i++) shadow_mark[i] = lpht_pkg::MARK_EMPTY;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_table();
    test_duplicate_keys();
    test_single_slot();
    test_shrunk_table();
    test_random_traffic(11'd1025, 0, 100);
    test_random_traffic(11'd37, 83, 100);
    test_random_traffic(11'd7, 0, 60);
    test_random_traffic(11'd1024, 19, 80);
    test_random_traffic(11'd300, 19, 60);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
